// ===== rtl/core/mad_pkg.sv =====
// -----------------------------------------------------------------------------
// mad_pkg
// Shared types, opcode patterns and decode helpers for the MOV/ADD
// instruction decoder.
// -----------------------------------------------------------------------------
package mad_pkg;

  // Opcode group masks and patterns.
  localparam logic [7:0] MASK_GRP4     = 8'b1111_1100;
  localparam logic [7:0] MASK_GRP16    = 8'b1111_0000;
  localparam logic [7:0] MASK_GRP2     = 8'b1111_1110;
  localparam logic [7:0] PAT_MOV_RM    = 8'b1000_1000;
  localparam logic [7:0] PAT_MOV_IMM_R = 8'b1011_0000;
  localparam logic [7:0] PAT_MOV_IMM_M = 8'b1100_0110;
  localparam logic [7:0] PAT_MOV_ACC   = 8'b1010_0000;
  localparam logic [7:0] PAT_ADD_RM    = 8'b0000_0000;
  localparam logic [7:0] PAT_ADD_IMM_M = 8'b1000_0000;

  // ModR/M codes.
  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_DISP16  = 2'd2;
  localparam logic [2:0] RM_DIRECT   = 3'b110;

  typedef enum logic [2:0] {
    K_MOV_RM      = 3'd0,
    K_MOV_IMM_REG = 3'd1,
    K_MOV_IMM_RM  = 3'd2,
    K_MOV_ACC     = 3'd3,
    K_ADD_RM      = 3'd4,
    K_ADD_IMM_RM  = 3'd5,
    K_UNKNOWN     = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    LEN_NONE = 2'd0,
    LEN_BYTE = 2'd1,
    LEN_WORD = 2'd2
  } len_t;

  typedef enum logic [1:0] {
    ST_DECODED  = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_TRUNCATE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FORM_REG_RM  = 2'd0,
    FORM_IMM_REG = 2'd1,
    FORM_IMM_RM  = 2'd2,
    FORM_ACC     = 2'd3
  } form_t;

  localparam logic OPER_MOV = 1'b0;
  localparam logic OPER_ADD = 1'b1;

  // One result record.
  typedef struct packed {
    status_t            status;
    logic               operation;
    form_t              form;
    logic               wide;
    logic               direction;
    logic [2:0]         reg_code;
    logic [1:0]         mod_code;
    logic [2:0]         rm_code;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [7:0]         opcode_byte;
  } result_t;

  // Classify a first byte.
  function automatic kind_t kind_of(input logic [7:0] op);
    kind_t k;
    if ((op & MASK_GRP4) == PAT_MOV_RM)            k = K_MOV_RM;
    else if ((op & MASK_GRP16) == PAT_MOV_IMM_R)   k = K_MOV_IMM_REG;
    else if ((op & MASK_GRP2) == PAT_MOV_IMM_M)    k = K_MOV_IMM_RM;
    else if ((op & MASK_GRP4) == PAT_MOV_ACC)      k = K_MOV_ACC;
    else if ((op & MASK_GRP4) == PAT_ADD_RM)       k = K_ADD_RM;
    else if ((op & MASK_GRP4) == PAT_ADD_IMM_M)    k = K_ADD_IMM_RM;
    else                                           k = K_UNKNOWN;
    return k;
  endfunction

  function automatic logic has_modrm(input kind_t k);
    return (k == K_MOV_RM) || (k == K_MOV_IMM_RM) || (k == K_ADD_RM) ||
           (k == K_ADD_IMM_RM);
  endfunction

  // Immediate length of an opcode.
  function automatic len_t imm_len(input logic [7:0] op);
    kind_t k;
    len_t  l;
    k = kind_of(op);
    l = LEN_NONE;
    case (k)
      K_MOV_IMM_REG: l = op[3] ? LEN_WORD : LEN_BYTE;
      K_MOV_IMM_RM:  l = op[0] ? LEN_WORD : LEN_BYTE;
      K_ADD_IMM_RM:  l = (op[1:0] == 2'b01) ? LEN_WORD : LEN_BYTE;
      default:       l = LEN_NONE;
    endcase
    return l;
  endfunction

  // Displacement length given the opcode and the ModR/M byte.
  function automatic len_t disp_len(input logic [7:0] op, input logic [7:0] modrm);
    kind_t k;
    len_t  l;
    k = kind_of(op);
    l = LEN_NONE;
    if (k == K_MOV_ACC) begin
      l = LEN_WORD;
    end else if (has_modrm(k)) begin
      if (modrm[7:6] == MOD_DISP8) l = LEN_BYTE;
      else if (modrm[7:6] == MOD_DISP16) l = LEN_WORD;
      else if (modrm[7:6] == MOD_NO_DISP && modrm[2:0] == RM_DIRECT) l = LEN_WORD;
    end
    return l;
  endfunction

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

// ===== rtl/core/mad_in_if.sv =====
// -----------------------------------------------------------------------------
// mad_in_if
// Byte stream channel into the decoder.
// -----------------------------------------------------------------------------
interface mad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

// ===== rtl/core/mad_out_if.sv =====
// -----------------------------------------------------------------------------
// mad_out_if
// Decoded instruction record channel out of the decoder.
// -----------------------------------------------------------------------------
interface mad_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               operation;
  logic [1:0]         form;
  logic               wide;
  logic               direction;
  logic [2:0]         reg_code;
  logic [1:0]         mod_code;
  logic [2:0]         rm_code;
  logic signed [15:0] displacement;
  logic signed [15:0] immediate;
  logic [7:0]         opcode_byte;

  modport source (output valid, status, operation, form, wide, direction, reg_code,
                  mod_code, rm_code, displacement, immediate, opcode_byte,
                  input ready);
  modport sink   (input valid, status, operation, form, wide, direction, reg_code,
                  mod_code, rm_code, displacement, immediate, opcode_byte,
                  output ready);
endinterface

// ===== rtl/core/mad_in_stage.sv =====
// -----------------------------------------------------------------------------
// mad_in_stage
// Input register: holds one byte until the decode step consumes it.
// -----------------------------------------------------------------------------
module mad_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  output logic       in_ready,
  input  logic       take,
  output logic       s1_valid,
  output logic [7:0] s1_byte,
  output logic       s1_eos
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       eos_r;

  // The stage can load whenever it is empty or its byte leaves this cycle.
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
      eos_r  <= in_eos;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;
  assign s1_eos   = eos_r;

endmodule

// ===== rtl/core/mad_decoder.sv =====
// -----------------------------------------------------------------------------
// mad_decoder
// Decode state machine: one byte per step, gathers ModR/M, displacement and
// immediate; forms a record per finished, unknown or truncated instruction.
// -----------------------------------------------------------------------------
module mad_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 eos,
  output logic                 res_valid,
  output mad_pkg::result_t     res
);

  typedef enum logic [3:0] {
    PH_OPCODE = 4'b0001,
    PH_MODRM  = 4'b0010,
    PH_DISP   = 4'b0100,
    PH_IMM    = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  modrm_r, modrm_nxt;
  logic [15:0] disp_r, disp_nxt;
  logic [15:0] imm_r, imm_nxt;
  logic        idx_r, idx_nxt;
  logic        halted_r, halted_nxt;

  // Build a decoded record from the finished latches.
  function automatic mad_pkg::result_t make_record(input logic [7:0] op,
                                                   input logic [7:0] modrm,
                                                   input logic [15:0] disp,
                                                   input logic [15:0] imm);
    mad_pkg::result_t r;
    mad_pkg::kind_t   k;
    k = mad_pkg::kind_of(op);
    r = '0;
    r.status    = mad_pkg::ST_DECODED;
    r.operation = (k == mad_pkg::K_ADD_RM || k == mad_pkg::K_ADD_IMM_RM) ?
                  mad_pkg::OPER_ADD : mad_pkg::OPER_MOV;
    case (k)
      mad_pkg::K_MOV_RM, mad_pkg::K_ADD_RM: begin
        r.form      = mad_pkg::FORM_REG_RM;
        r.wide      = op[0];
        r.direction = op[1];
        r.reg_code  = modrm[5:3];
      end
      mad_pkg::K_MOV_IMM_REG: begin
        r.form     = mad_pkg::FORM_IMM_REG;
        r.wide     = op[3];
        r.reg_code = op[2:0];
      end
      mad_pkg::K_MOV_IMM_RM, mad_pkg::K_ADD_IMM_RM: begin
        r.form     = mad_pkg::FORM_IMM_RM;
        r.wide     = op[0];
        r.reg_code = modrm[5:3];
      end
      default: begin
        r.form      = mad_pkg::FORM_ACC;
        r.wide      = op[0];
        r.direction = op[1];
      end
    endcase
    if (mad_pkg::has_modrm(k)) begin
      r.mod_code = modrm[7:6];
      r.rm_code  = modrm[2:0];
    end
    r.displacement = disp;
    r.immediate    = imm;
    r.opcode_byte  = op;
    return r;
  endfunction

  // One decode step on the current byte. The record flag tells whether the
  // byte on the inputs would give a record; the state moves only on a step.
  always_comb begin
    phase_t         ph_next;
    logic           done;
    mad_pkg::kind_t k;
    mad_pkg::len_t  dl;
    mad_pkg::len_t  il;

    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    modrm_nxt  = modrm_r;
    disp_nxt   = disp_r;
    imm_nxt    = imm_r;
    idx_nxt    = idx_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '0;
    ph_next    = PH_OPCODE;
    done       = 1'b0;
    k          = mad_pkg::kind_of(data_byte);
    dl         = mad_pkg::LEN_NONE;
    il         = mad_pkg::imm_len(opcode_r);

    if (!halted_r) begin
      case (phase_r)
        PH_MODRM: begin
          modrm_nxt = data_byte;
          if (mad_pkg::disp_len(opcode_r, data_byte) != mad_pkg::LEN_NONE) begin
            ph_next = PH_DISP;
          end else if (il != mad_pkg::LEN_NONE) begin
            ph_next = PH_IMM;
          end else begin
            done = 1'b1;
          end
        end
        PH_DISP: begin
          dl = mad_pkg::disp_len(opcode_r, modrm_r);
          if (dl == mad_pkg::LEN_BYTE || idx_r) begin
            if (dl == mad_pkg::LEN_BYTE) begin
              disp_nxt = mad_pkg::sext8(data_byte);
            end else begin
              disp_nxt = {data_byte, disp_r[7:0]};
            end
            idx_nxt = 1'b0;
            if (il != mad_pkg::LEN_NONE) ph_next = PH_IMM;
            else done = 1'b1;
          end else begin
            disp_nxt = {8'h00, data_byte};
            idx_nxt  = 1'b1;
            ph_next  = PH_DISP;
          end
        end
        PH_IMM: begin
          if (il == mad_pkg::LEN_BYTE) begin
            imm_nxt = mad_pkg::sext8(data_byte);
            done    = 1'b1;
          end else if (idx_r) begin
            imm_nxt = {data_byte, imm_r[7:0]};
            idx_nxt = 1'b0;
            done    = 1'b1;
          end else begin
            imm_nxt = {8'h00, data_byte};
            idx_nxt = 1'b1;
            ph_next = PH_IMM;
          end
        end
        default: begin
          // Opcode byte, also taken for any phase code without meaning.
          opcode_nxt = data_byte;
          modrm_nxt  = '0;
          disp_nxt   = '0;
          imm_nxt    = '0;
          idx_nxt    = 1'b0;
          if (mad_pkg::has_modrm(k)) ph_next = PH_MODRM;
          else if (k == mad_pkg::K_MOV_ACC) ph_next = PH_DISP;
          else ph_next = PH_IMM;
        end
      endcase

      if (phase_r != PH_MODRM && phase_r != PH_DISP && phase_r != PH_IMM &&
          k == mad_pkg::K_UNKNOWN) begin
        // Unknown opcode: report it and stop until reset.
        opcode_nxt      = opcode_r;
        modrm_nxt       = modrm_r;
        disp_nxt        = disp_r;
        imm_nxt         = imm_r;
        idx_nxt         = idx_r;
        phase_nxt       = PH_OPCODE;
        halted_nxt      = 1'b1;
        res_valid       = 1'b1;
        res.status      = mad_pkg::ST_UNKNOWN;
        res.opcode_byte = data_byte;
      end else if (done) begin
        res_valid = 1'b1;
        res       = make_record(opcode_nxt, modrm_nxt, disp_nxt, imm_nxt);
        phase_nxt = PH_OPCODE;
        idx_nxt   = 1'b0;
      end else if (eos) begin
        // Stream ended inside an instruction.
        res_valid       = 1'b1;
        res.status      = mad_pkg::ST_TRUNCATE;
        res.opcode_byte = opcode_nxt;
        phase_nxt       = PH_OPCODE;
        idx_nxt         = 1'b0;
      end else begin
        phase_nxt = ph_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      opcode_r <= '0;
      modrm_r  <= '0;
      disp_r   <= '0;
      imm_r    <= '0;
      idx_r    <= 1'b0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      modrm_r  <= modrm_nxt;
      disp_r   <= disp_nxt;
      imm_r    <= imm_nxt;
      idx_r    <= idx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ===== rtl/core/mad_out_stage.sv =====
// -----------------------------------------------------------------------------
// mad_out_stage
// Result register: holds one record until the consumer takes it.
// -----------------------------------------------------------------------------
module mad_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mad_pkg::result_t load_res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output mad_pkg::result_t out_res
);

  logic             valid_r;
  mad_pkg::result_t res_r;

  // A new record may enter when the register is empty or drains this cycle.
  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= load_res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/core/mov_add_instruction_decoder.sv =====
// -----------------------------------------------------------------------------
// mov_add_instruction_decoder
// Byte-serial decoder for MOV and ADD forms of the 16-bit x86 code stream.
// -----------------------------------------------------------------------------
// The block takes one code byte per cycle and returns one record for each
// finished instruction, for an unknown opcode (after which it ignores all
// bytes until reset), or for a stream that ends inside an instruction. Every
// request is one byte; a byte is taken in each cycle as long as the result
// side keeps up, and the input and result registers let a new byte enter
// while a finished record still waits. Once the last byte of an instruction is
// accepted, it sits in the input register, and the single decode step on it
// writes the record into the result register. A byte that would give a record
// waits in the input register while the result register is full and not
// draining. The decode step is one small state update per byte and sets the
// rate of one byte per cycle.
// -----------------------------------------------------------------------------
module mov_add_instruction_decoder (
  input logic        clk,
  input logic        rst_n,
  mad_in_if.sink     in_chan,
  mad_out_if.source  out_chan
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_eos;
  logic             advance;
  logic             dec_valid;
  mad_pkg::result_t dec_res;
  logic             out_free;
  mad_pkg::result_t out_res;

  // The byte leaves the input register unless its record cannot be stored.
  assign advance = s1_valid && (!dec_valid || out_free);

  mad_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.data_byte),
    .in_eos   (in_chan.end_of_stream),
    .in_ready (in_chan.ready),
    .take     (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .s1_eos   (s1_eos)
  );

  mad_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte),
    .eos       (s1_eos),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  mad_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && dec_valid),
    .load_res  (dec_res),
    .free      (out_free),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // Result fields onto the channel.
  assign out_chan.status       = out_res.status;
  assign out_chan.operation    = out_res.operation;
  assign out_chan.form         = out_res.form;
  assign out_chan.wide         = out_res.wide;
  assign out_chan.direction    = out_res.direction;
  assign out_chan.reg_code     = out_res.reg_code;
  assign out_chan.mod_code     = out_res.mod_code;
  assign out_chan.rm_code      = out_res.rm_code;
  assign out_chan.displacement = out_res.displacement;
  assign out_chan.immediate    = out_res.immediate;
  assign out_chan.opcode_byte  = out_res.opcode_byte;

endmodule
